>>> hw/rtl/string_key_double_hash_table_core_macros.svh
// Assertion macros for the string-key double-hash table core.
// Used by the top level; empty when SYNTHESIS is defined.
`ifndef STRING_KEY_DOUBLE_HASH_TABLE_CORE_MACROS_SVH
`define STRING_KEY_DOUBLE_HASH_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SKDHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SKDHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKDHT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SKDHT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/skdht_pkg.sv
// Package for the string-key double-hash table core: defaults, status codes
// and the two name hash step functions. No dependencies.
package skdht_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int NAME_CHARS_DEF    = 32;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ALREADY  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TOOLONG  = 3'd4;

  // Rotate-5 XOR hash step.
  function automatic logic [31:0] primary_next(input logic [31:0] h, input logic [31:0] c);
    logic [31:0] top;
    logic [31:0] v;
    top = h & 32'hf8000000;
    v   = (h & 32'h07ffffff) << 5;
    v   = v ^ (top >> 27);
    return v ^ c;
  endfunction

  // Shift-4 folded hash step; folding with a zero top nibble changes nothing.
  function automatic logic [31:0] step_next(input logic [31:0] h, input logic [31:0] c);
    logic [31:0] top;
    logic [31:0] v;
    v   = ((h & 32'h0fffffff) << 4) + c;
    top = v & 32'hf0000000;
    v   = v ^ (top >> 24);
    return v ^ top;
  endfunction

endpackage

>>> hw/rtl/string_key_double_hash_table_core.sv
// String-key hash table with double hashing. Names arrive one byte per
// request, one request per cycle while the core is idle; a request with tlast
// ends the name and starts the table operation (tuser: 0 lookup, 1 register).
// Each slot probe reads the metadata, then checks it; when the stored length
// matches, each character is read from the single-port character memory and
// then compared. Registering a new name copies it character by character
// into the character memory. The walk is bounded by TABLE_ENTRIES probes.
// Names longer than NAME_CHARS report status 4. The per-slot valid bits are
// flip-flops cleared by reset, so no clearing pass is needed. One result may
// wait in the output register while the next name is taken in.
// Depends on skdht_pkg, skdht_hash and the macros header.
`include "string_key_double_hash_table_core_macros.svh"
module string_key_double_hash_table_core import skdht_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int NAME_CHARS    = NAME_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] name_byte, [15:8] message_index
  input  logic        in_tuser,   // [0] kind
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] status, [10:3] slot_index, [18:11] stored_index
);

  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int LEN_W  = $clog2(NAME_CHARS + 1);
  localparam int K_W    = $clog2(NAME_CHARS);
  localparam int ADDR_W = $clog2(TABLE_ENTRIES * NAME_CHARS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_META = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_CRD  = 7'b0001000,
    S_CCMP = 7'b0010000,
    S_WR   = 7'b0100000,
    S_RES  = 7'b1000000
  } state_t;

  state_t state_r;

  logic             in_acc;
  logic [LEN_W-1:0] len_cur, len_fin;
  logic             ovf_fin;
  logic [31:0]      prim_fin, step_fin;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  skdht_hash #(.NAME_CHARS(NAME_CHARS), .LEN_W(LEN_W)) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_acc),
    .name_byte(in_tdata[7:0]),
    .last     (in_tlast),
    .len_cur  (len_cur),
    .len_fin  (len_fin),
    .ovf_fin  (ovf_fin),
    .prim_fin (prim_fin),
    .step_fin (step_fin)
  );

  // Name buffer for the request being assembled.
  logic [7:0] nbuf_r [NAME_CHARS];
  always_ff @(posedge clk) begin
    if (in_acc && (len_cur < LEN_W'(NAME_CHARS))) begin
      nbuf_r[len_cur[K_W-1:0]] <= in_tdata[7:0];
    end
  end

  // Slot metadata memory (length, message index) and character memory.
  logic [LEN_W+7:0] meta_mem [TABLE_ENTRIES];
  logic [7:0]       chr_mem  [TABLE_ENTRIES * NAME_CHARS];
  logic [LEN_W+7:0] meta_rd_r;
  logic [7:0]       chr_rd_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [SLOT_W-1:0] offs_r, step_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LEN_W-1:0]  plen_r;
  logic [K_W-1:0]    k_r;
  logic              kind_r;
  logic [7:0]        msg_r;
  logic [2:0]        res_st_r;
  logic [7:0]        res_slot_r, res_stored_r;
  logic              out_tvalid_r;
  logic [23:0]       out_tdata_r;

  logic [ADDR_W-1:0] chr_addr;
  logic [31:0]       offs_wide;
  logic              slot_empty, len_match, chr_last, probe_end;
  logic [LEN_W-1:0]  meta_len;
  logic [7:0]        meta_msg;

  always_comb begin
    chr_addr   = ADDR_W'(offs_r) * ADDR_W'(NAME_CHARS) + ADDR_W'(k_r);
    offs_wide  = 32'(offs_r);
    slot_empty = !valid_r[offs_r];
    meta_len   = meta_rd_r[LEN_W+7:8];
    meta_msg   = meta_rd_r[7:0];
    len_match  = (meta_len == plen_r);
    chr_last   = (LEN_W'(k_r) + 1'b1) == plen_r;
    probe_end  = (cnt_r + 1'b1) == CNT_W'(TABLE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_META) begin
      meta_rd_r <= meta_mem[offs_r];
    end
    if ((state_r == S_CHK) && slot_empty && kind_r) begin
      meta_mem[offs_r] <= {plen_r, msg_r};
    end
    if (state_r == S_CRD) begin
      chr_rd_r <= chr_mem[chr_addr];
    end
    if (state_r == S_WR) begin
      chr_mem[chr_addr] <= nbuf_r[k_r];
    end
  end

  // Probe datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tlast) begin
          offs_r       <= prim_fin[SLOT_W-1:0];
          step_r       <= step_fin[SLOT_W-1:0];
          plen_r       <= len_fin;
          kind_r       <= in_tuser;
          msg_r        <= in_tdata[15:8];
          cnt_r        <= '0;
          res_st_r     <= ST_TOOLONG;
          res_slot_r   <= 8'd0;
          res_stored_r <= 8'd0;
        end
      end
      S_CHK: begin
        k_r <= '0;
        if (slot_empty) begin
          if (kind_r) begin
            res_st_r     <= ST_OK;
            res_slot_r   <= offs_wide[7:0];
            res_stored_r <= msg_r;
          end else begin
            res_st_r <= ST_NOTFOUND;
          end
        end else if (!len_match) begin
          offs_r   <= offs_r + step_r;
          cnt_r    <= cnt_r + 1'b1;
          res_st_r <= kind_r ? ST_FULL : ST_NOTFOUND;
        end
      end
      S_CCMP: begin
        if (chr_rd_r != nbuf_r[k_r]) begin
          offs_r   <= offs_r + step_r;
          cnt_r    <= cnt_r + 1'b1;
          res_st_r <= kind_r ? ST_FULL : ST_NOTFOUND;
        end else if (chr_last) begin
          res_st_r     <= kind_r ? ST_ALREADY : ST_OK;
          res_slot_r   <= offs_wide[7:0];
          res_stored_r <= meta_msg;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      S_WR: begin
        k_r <= k_r + 1'b1;
      end
      S_RES: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_r <= {5'd0, res_stored_r, res_slot_r, res_st_r};
        end
      end
      default: begin
      end
    endcase
  end

  // Control: state, valid bits, output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // The output register is loaded when it is empty or drained this cycle.
      if ((state_r == S_RES) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_tlast) begin
            state_r <= ovf_fin ? S_RES : S_META;
          end
        end
        S_META: state_r <= S_CHK;
        S_CHK: begin
          if (slot_empty) begin
            if (kind_r) begin
              valid_r[offs_r] <= 1'b1;
              state_r         <= S_WR;
            end else begin
              state_r <= S_RES;
            end
          end else if (len_match) begin
            state_r <= S_CRD;
          end else begin
            state_r <= probe_end ? S_RES : S_META;
          end
        end
        S_CRD: state_r <= S_CCMP;
        S_CCMP: begin
          if (chr_rd_r != nbuf_r[k_r]) begin
            state_r <= probe_end ? S_RES : S_META;
          end else if (chr_last) begin
            state_r <= S_RES;
          end else begin
            state_r <= S_CRD;
          end
        end
        S_WR: begin
          if (chr_last) begin
            state_r <= S_RES;
          end
        end
        S_RES: begin
          if (!out_tvalid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A final byte always leaves the idle state on the next cycle.
  `SKDHT_ASSERT_NXT(a_last_starts, clk, rst_n, in_acc && in_tlast, state_r != S_IDLE)
  // Character compares never run past the stored name length.
  `SKDHT_ASSERT_IMP(a_cmp_in_len, clk, rst_n, state_r == S_CCMP, LEN_W'(k_r) < plen_r)
  // A name copy only targets a slot already marked taken.
  `SKDHT_ASSERT_IMP(a_wr_valid, clk, rst_n, state_r == S_WR, valid_r[offs_r])

endmodule

>>> hw/rtl/skdht_hash.sv
// Running name hashes, name length and overflow flag for the table core.
// Depends on skdht_pkg.
module skdht_hash import skdht_pkg::*; #(
  parameter int NAME_CHARS = NAME_CHARS_DEF,
  parameter int LEN_W      = $clog2(NAME_CHARS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_vld,
  input  logic [7:0]       name_byte,
  input  logic             last,
  output logic [LEN_W-1:0] len_cur,
  output logic [LEN_W-1:0] len_fin,
  output logic             ovf_fin,
  output logic [31:0]      prim_fin,
  output logic [31:0]      step_fin
);

  logic [31:0]      prim_r, prim_nxt, step_r, step_nxt, c;
  logic [LEN_W-1:0] len_r;
  logic             ovf_r, first, room;

  always_comb begin
    c        = {{24{name_byte[7]}}, name_byte};
    first    = (len_r == '0) && !ovf_r;
    room     = len_r < LEN_W'(NAME_CHARS);
    prim_nxt = first ? c : primary_next(prim_r, c);
    step_nxt = first ? c : step_next(step_r, c);
    prim_fin = primary_next(prim_nxt, 32'd0);
    step_fin = step_next(step_nxt, 32'd0) | 32'd1;
    ovf_fin  = ovf_r || !room;
    len_fin  = room ? len_r + 1'b1 : len_r;
    len_cur  = len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else if (byte_vld) begin
      if (last) begin
        len_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        len_r <= len_fin;
        ovf_r <= ovf_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld) begin
      prim_r <= prim_nxt;
      step_r <= step_nxt;
    end
  end

endmodule
